>>> rtl/glyph_clip_blit_top_defines.svh
// Assertion macros shared by the glyph blitter RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef GLYPH_CLIP_BLIT_TOP_DEFINES_SVH
`define GLYPH_CLIP_BLIT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define GCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define GCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gcb_pkg.sv
// Types, register map and helper functions for the glyph blitter.
// No dependencies; used by glyph_clip_blit_top.
package gcb_pkg;

  // Input word opcodes
  typedef enum logic [1:0] {
    OP_PEN      = 2'd0,
    OP_HEADER   = 2'd1,
    OP_COVERAGE = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  // Register index within the APB window (paddr[3:2])
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BASELINE_BIAS = 2'd2;

  localparam logic [12:0] WIDTH_RST  = 13'd1024;
  localparam logic [12:0] HEIGHT_RST = 13'd600;
  localparam logic [7:0]  BIAS_RST   = 8'd0;

  // Pack RGB888 into RGB565
  function automatic logic [15:0] rgb565(input logic [23:0] c);
    rgb565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

  // Saturate a 17-bit signed sum to 16-bit signed
  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] res;
    if (v[16] == v[15]) begin
      res = v[15:0];
    end else if (v[16]) begin
      res = 16'sh8000;
    end else begin
      res = 16'sh7FFF;
    end
    sat16 = res;
  endfunction

  // Signed 11.6 value divided by 64, truncated toward zero
  function automatic logic signed [10:0] adv_px(input logic signed [16:0] a);
    adv_px = a[16:6] + {10'd0, (a[16] && (a[5:0] != 6'd0))};
  endfunction

endpackage

>>> rtl/glyph_clip_blit_top.sv
// Color-expand glyph blitter top level: pen/header state, clip test,
// address multiply-add. Depends on gcb_pkg and glyph_clip_blit_top_defines.svh.

// One input word is taken every cycle unless the input stalls; each accepted word
// updates pen and raster state in the cycle it is taken. A visible,
// nonzero coverage byte moves into a stage register holding the clipped row and
// column, and the next stage forms row * width + column in a 13x13 multiply-add
// feeding the output register, from which the pixel write is presented. The input
// stalls only when both stages hold a pixel and the output word is not being taken.
// Width and height are limited to MAX_WIDTH and MAX_HEIGHT; the limited width is
// also the row stride. Registers must be written through APB only while idle; the
// block itself does not enforce this.
`include "glyph_clip_blit_top_defines.svh"

module glyph_clip_blit_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic signed [15:0] in_pen_x,
  input  logic signed [15:0] in_pen_y,
  input  logic [23:0]        in_text_color,
  input  logic signed [10:0] in_bearing_left,
  input  logic signed [10:0] in_bearing_top,
  input  logic [7:0]         in_bitmap_columns,
  input  logic [7:0]         in_bitmap_rows,
  input  logic signed [16:0] in_advance_x,
  input  logic signed [16:0] in_advance_y,
  input  logic [7:0]         in_coverage,
  // pixel write words
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_write_address,
  output logic [15:0]        out_pixel_color,
  // APB register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [13:0] MaxW = 14'(MAX_WIDTH);
  localparam logic [13:0] MaxH = 14'(MAX_HEIGHT);

  // configuration registers
  logic [12:0] screen_width_r, screen_height_r;
  logic [7:0]  baseline_bias_r;

  // pen and glyph state
  logic signed [15:0] pen_col_r, pen_col_nxt;
  logic signed [15:0] pen_row_r, pen_row_nxt;
  logic [15:0]        color565_r, color565_nxt;
  logic signed [17:0] origin_col_r, origin_col_nxt;
  logic signed [17:0] origin_row_r, origin_row_nxt;
  logic [7:0]         glyph_cols_r, glyph_cols_nxt;
  logic [7:0]         rows_left_r, rows_left_nxt;
  logic [7:0]         col_index_r, col_index_nxt;
  logic [7:0]         row_index_r, row_index_nxt;

  // pixel stage and output stage
  logic        s1_valid_r, s1_valid_nxt;
  logic [12:0] s1_row_r, s1_col_r;
  logic [15:0] s1_color_r;
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_addr_r;
  logic [15:0] out_color_r;

  logic              in_fire, out_load, s1_adv, s1_load;
  logic              glyph_active, on_screen;
  gcb_pkg::op_t      op;
  logic [12:0]       w_eff, h_eff;
  logic signed [18:0] pix_col, pix_row;
  logic [7:0]        col_inc;
  logic [25:0]       addr_full;

  // APB: always ready, write on access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= gcb_pkg::WIDTH_RST;
      screen_height_r <= gcb_pkg::HEIGHT_RST;
      baseline_bias_r <= gcb_pkg::BIAS_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        gcb_pkg::REG_SCREEN_WIDTH:  screen_width_r  <= pwdata[12:0];
        gcb_pkg::REG_SCREEN_HEIGHT: screen_height_r <= pwdata[12:0];
        gcb_pkg::REG_BASELINE_BIAS: baseline_bias_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      gcb_pkg::REG_SCREEN_WIDTH:  prdata = {19'd0, screen_width_r};
      gcb_pkg::REG_SCREEN_HEIGHT: prdata = {19'd0, screen_height_r};
      gcb_pkg::REG_BASELINE_BIAS: prdata = {24'd0, baseline_bias_r};
      default:                    prdata = 32'd0;
    endcase
  end

  // limit screen size to the supported maximum
  assign w_eff = ({1'b0, screen_width_r} < MaxW) ? screen_width_r : MaxW[12:0];
  assign h_eff = ({1'b0, screen_height_r} < MaxH) ? screen_height_r : MaxH[12:0];

  // handshakes: output register frees, pixel stage moves, input taken
  assign out_load = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;
  assign in_fire  = in_valid && in_ready;
  assign op       = gcb_pkg::op_t'(in_opcode);

  // current raster pixel and clip test
  assign glyph_active = (glyph_cols_r != 8'd0) && (rows_left_r != 8'd0);
  assign pix_col = {origin_col_r[17], origin_col_r} + {11'd0, col_index_r};
  assign pix_row = {origin_row_r[17], origin_row_r} + {11'd0, row_index_r};
  assign on_screen = !pix_col[18] && !pix_row[18] &&
                     (pix_col < {6'd0, w_eff}) && (pix_row < {6'd0, h_eff});
  assign col_inc = col_index_r + 8'd1;
  assign s1_load = in_fire && (op == gcb_pkg::OP_COVERAGE) && glyph_active &&
                   (in_coverage != 8'd0) && on_screen;

  // next pen, glyph and raster state for the accepted word
  always_comb begin
    pen_col_nxt    = pen_col_r;
    pen_row_nxt    = pen_row_r;
    color565_nxt   = color565_r;
    origin_col_nxt = origin_col_r;
    origin_row_nxt = origin_row_r;
    glyph_cols_nxt = glyph_cols_r;
    rows_left_nxt  = rows_left_r;
    col_index_nxt  = col_index_r;
    row_index_nxt  = row_index_r;
    if (in_fire) begin
      unique case (op)
        gcb_pkg::OP_PEN: begin
          pen_col_nxt  = in_pen_x;
          pen_row_nxt  = in_pen_y;
          color565_nxt = gcb_pkg::rgb565(in_text_color);
        end
        gcb_pkg::OP_HEADER: begin
          origin_col_nxt = {{2{pen_col_r[15]}}, pen_col_r}
                         + {{7{in_bearing_left[10]}}, in_bearing_left};
          origin_row_nxt = {{2{pen_row_r[15]}}, pen_row_r}
                         - {{7{in_bearing_top[10]}}, in_bearing_top}
                         + {10'd0, baseline_bias_r};
          glyph_cols_nxt = in_bitmap_columns;
          rows_left_nxt  = in_bitmap_rows;
          col_index_nxt  = 8'd0;
          row_index_nxt  = 8'd0;
          pen_col_nxt = gcb_pkg::sat16({pen_col_r[15], pen_col_r}
                        + 17'(gcb_pkg::adv_px(in_advance_x)));
          pen_row_nxt = gcb_pkg::sat16({pen_row_r[15], pen_row_r}
                        - 17'(gcb_pkg::adv_px(in_advance_y)));
        end
        gcb_pkg::OP_COVERAGE: begin
          if (glyph_active) begin
            if (col_inc >= glyph_cols_r) begin
              col_index_nxt = 8'd0;
              row_index_nxt = row_index_r + 8'd1;
              rows_left_nxt = rows_left_r - 8'd1;
            end else begin
              col_index_nxt = col_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_col_r    <= '0;
      pen_row_r    <= '0;
      color565_r   <= '0;
      origin_col_r <= '0;
      origin_row_r <= '0;
      glyph_cols_r <= '0;
      rows_left_r  <= '0;
      col_index_r  <= '0;
      row_index_r  <= '0;
    end else begin
      pen_col_r    <= pen_col_nxt;
      pen_row_r    <= pen_row_nxt;
      color565_r   <= color565_nxt;
      origin_col_r <= origin_col_nxt;
      origin_row_r <= origin_row_nxt;
      glyph_cols_r <= glyph_cols_nxt;
      rows_left_r  <= rows_left_nxt;
      col_index_r  <= col_index_nxt;
      row_index_r  <= row_index_nxt;
    end
  end

  // pipeline valid flags
  always_comb begin
    priority if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    priority if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold clipped pixel position and color
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_row_r   <= pix_row[12:0];
      s1_col_r   <= pix_col[12:0];
      s1_color_r <= color565_r;
    end
  end

  // form framebuffer index row * stride + column
  assign addr_full = ({13'd0, s1_row_r} * {13'd0, w_eff}) + {13'd0, s1_col_r};

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_addr_r  <= addr_full[23:0];
      out_color_r <= s1_color_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = out_addr_r;
  assign out_pixel_color   = out_color_r;

  // checks
  `GCB_ASSERT_NOW(a_stall_only_full, !in_ready, s1_valid_r && out_valid_r && !out_ready,
    "input stalled while pipeline has room")
  `GCB_ASSERT_NOW(a_col_in_range, glyph_cols_r != 8'd0, col_index_r < glyph_cols_r,
    "raster column ran past glyph width")
  `GCB_ASSERT_NOW(a_stage_clipped, s1_valid_r, (s1_row_r < h_eff) && (s1_col_r < w_eff),
    "pixel stage holds an off-screen position")
  `GCB_ASSERT_NEXT(a_pen_keeps_raster, in_fire && op == gcb_pkg::OP_PEN,
    $stable(col_index_r) && $stable(rows_left_r), "pen word moved the raster")

endmodule

>>> dv/glyph_blit_check_pkg.sv
// Input word and pixel write types plus the expected-write tracker for the glyph blitter bench.
// Depends on gcb_pkg for opcodes and register indexes.
`timescale 1ns / 100ps

package glyph_blit_check_pkg;

  localparam int FB_MAX_WIDTH  = 4096;
  localparam int FB_MAX_HEIGHT = 4096;

  // One input word, every field at its port width
  typedef struct {
    gcb_pkg::op_t       op;
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;
    logic [23:0]        color;
    logic signed [10:0] left;
    logic signed [10:0] top;
    logic [7:0]         cols;
    logic [7:0]         rows;
    logic signed [16:0] adv_x;
    logic signed [16:0] adv_y;
    logic [7:0]         cov;
  } glyph_word_t;

  typedef struct {
    logic [23:0] addr;
    logic [15:0] color;
  } pixel_write_t;

  // Tracks pen, glyph raster and screen settings; queues the pixel writes they imply
  class pixel_write_tracker;
    int unsigned        width_reg;
    int unsigned        height_reg;
    int unsigned        bias_reg;
    logic signed [15:0] pen_col;
    logic signed [15:0] pen_row;
    logic [15:0]        color565;
    int                 origin_col;
    int                 origin_row;
    int unsigned        glyph_cols;
    int unsigned        rows_left;
    int unsigned        col_idx;
    int unsigned        row_idx;
    pixel_write_t       pending_writes[$];
    int                 errors;

    function new();
      width_reg  = 1024;
      height_reg = 600;
      bias_reg   = 0;
      pen_col    = '0;
      pen_row    = '0;
      color565   = '0;
      origin_col = 0;
      origin_row = 0;
      glyph_cols = 0;
      rows_left  = 0;
      col_idx    = 0;
      row_idx    = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        gcb_pkg::REG_SCREEN_WIDTH: begin
          width_reg = val[12:0];
        end
        gcb_pkg::REG_SCREEN_HEIGHT: begin
          height_reg = val[12:0];
        end
        gcb_pkg::REG_BASELINE_BIAS: begin
          bias_reg = val[7:0];
        end
        default: begin
        end
      endcase
    endfunction

    function logic signed [15:0] clamp16(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
    endfunction

    // Advance the model by one accepted word
    function void note_word(glyph_word_t w);
      int           eff_w;
      int           eff_h;
      int           col;
      int           row;
      int unsigned  c;
      pixel_write_t px;
      case (w.op)
        gcb_pkg::OP_PEN: begin
          c        = w.color;
          pen_col  = w.pen_x;
          pen_row  = w.pen_y;
          color565 = 16'(((c & 'hF80000) >> 8) | ((c & 'hFC00) >> 5) | ((c & 'hF8) >> 3));
        end
        gcb_pkg::OP_HEADER: begin
          origin_col = int'(pen_col) + int'(w.left);
          origin_row = int'(pen_row) - int'(w.top) + int'(bias_reg);
          glyph_cols = w.cols;
          rows_left  = w.rows;
          col_idx    = 0;
          row_idx    = 0;
          // advance divides toward zero; y moves up the screen
          pen_col    = clamp16(int'(pen_col) + int'(w.adv_x) / 64);
          pen_row    = clamp16(int'(pen_row) - int'(w.adv_y) / 64);
        end
        gcb_pkg::OP_COVERAGE: begin
          // drop bytes past the glyph end or for an empty glyph
          if (glyph_cols != 0 && rows_left != 0) begin
            eff_w = (width_reg < FB_MAX_WIDTH) ? int'(width_reg) : FB_MAX_WIDTH;
            eff_h = (height_reg < FB_MAX_HEIGHT) ? int'(height_reg) : FB_MAX_HEIGHT;
            col   = origin_col + int'(col_idx);
            row   = origin_row + int'(row_idx);
            if (w.cov != 0 && col >= 0 && row >= 0 && col < eff_w && row < eff_h) begin
              px.addr  = 24'(row * eff_w + col);
              px.color = color565;
              pending_writes.push_back(px);
            end
            col_idx++;
            if (col_idx >= glyph_cols) begin
              col_idx = 0;
              row_idx = (row_idx + 1) & 255;
              rows_left--;
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Compare a pixel write word against the oldest expected write
    task check_write(logic [23:0] addr, logic [15:0] color);
      pixel_write_t exp_px;
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write addr %h color %h", addr, color));
        return;
      end
      exp_px = pending_writes.pop_front();
      if (addr !== exp_px.addr)
        report_mismatch($sformatf("address %h, expected %h", addr, exp_px.addr));
      if (color !== exp_px.color)
        report_mismatch($sformatf("color %h at %h, expected %h", color, addr, exp_px.color));
    endtask
  endclass

endpackage

>>> dv/testbench.sv
// Top-level bench for glyph_clip_blit_top: directed and random word streams, APB setup,
// random stalls on both channels. Depends on gcb_pkg and glyph_blit_check_pkg.
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] out_write_address;
  logic [15:0] out_pixel_color;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  glyph_blit_check_pkg::glyph_word_t        cur_word;
  glyph_blit_check_pkg::pixel_write_tracker tracker;
  int                 sent_count = 0;
  int                 idle_cycles = 0;
  int                 out_hold = 0;
  int                 out_ticks = 0;
  bit                 in_calm = 1'b0;
  bit                 out_calm = 1'b0;
  int                 scr_w = 1024;
  int                 scr_h = 600;
  int                 scr_bias = 0;

  glyph_clip_blit_top #(
    .MAX_WIDTH (glyph_blit_check_pkg::FB_MAX_WIDTH),
    .MAX_HEIGHT(glyph_blit_check_pkg::FB_MAX_HEIGHT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (cur_word.op),
    .in_pen_x         (cur_word.pen_x),
    .in_pen_y         (cur_word.pen_y),
    .in_text_color    (cur_word.color),
    .in_bearing_left  (cur_word.left),
    .in_bearing_top   (cur_word.top),
    .in_bitmap_columns(cur_word.cols),
    .in_bitmap_rows   (cur_word.rows),
    .in_advance_x     (cur_word.adv_x),
    .in_advance_y     (cur_word.adv_y),
    .in_coverage      (cur_word.cov),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_address(out_write_address),
    .out_pixel_color  (out_pixel_color),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Coordinate near either screen edge, or anywhere across it
  function automatic int near_edge(int extent);
    case ($urandom_range(0, 2))
      0: return int'($urandom_range(0, 8)) - 6;
      1: return extent - 6 + int'($urandom_range(0, 8));
      default: return int'($urandom_range(0, extent + 16)) - 8;
    endcase
  endfunction

  function automatic glyph_blit_check_pkg::glyph_word_t random_word(gcb_pkg::op_t op);
    glyph_blit_check_pkg::glyph_word_t w;
    w.op    = op;
    w.pen_x = 16'($urandom);
    w.pen_y = 16'($urandom);
    w.color = 24'($urandom);
    w.left  = 11'($urandom);
    w.top   = 11'($urandom);
    w.cols  = 8'($urandom);
    w.rows  = 8'($urandom);
    w.adv_x = 17'($urandom);
    w.adv_y = 17'($urandom);
    w.cov   = 8'($urandom);
    return w;
  endfunction

  // Present one word, hold it until taken
  task automatic send_word(glyph_blit_check_pkg::glyph_word_t w);
    int gap;
    if (!in_calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      gap = pick_gap();
      repeat (gap) @(negedge clk);
    end
    cur_word = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (w.op != gcb_pkg::OP_NOP) sent_count++;
    @(negedge clk);
  endtask

  task automatic send_pen(int x, int y, int c);
    glyph_blit_check_pkg::glyph_word_t w;
    w       = random_word(gcb_pkg::OP_PEN);
    w.pen_x = 16'(x);
    w.pen_y = 16'(y);
    w.color = 24'(c);
    send_word(w);
  endtask

  task automatic send_header(int l, int t, int c, int r, int ax, int ay);
    glyph_blit_check_pkg::glyph_word_t w;
    w       = random_word(gcb_pkg::OP_HEADER);
    w.left  = 11'(l);
    w.top   = 11'(t);
    w.cols  = 8'(c);
    w.rows  = 8'(r);
    w.adv_x = 17'(ax);
    w.adv_y = 17'(ay);
    send_word(w);
  endtask

  task automatic send_cov(int b);
    glyph_blit_check_pkg::glyph_word_t w;
    w     = random_word(gcb_pkg::OP_COVERAGE);
    w.cov = 8'(b);
    send_word(w);
  endtask

  // Hold the input until every expected write is out, then let the pipe settle
  task automatic hold_until_drained();
    in_valid = 1'b0;
    while (tracker.pending_writes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read(logic [1:0] idx, output logic [31:0] val);
    psel    = 1'b1;
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    val = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Reprogram the screen while idle; upper data bits carry junk
  task automatic program_screen(int w, int h, int b);
    logic [31:0] rd;
    hold_until_drained();
    apb_write(gcb_pkg::REG_SCREEN_WIDTH, 32'(w) | ($urandom << 13));
    apb_write(gcb_pkg::REG_SCREEN_HEIGHT, 32'(h) | ($urandom << 13));
    apb_write(gcb_pkg::REG_BASELINE_BIAS, 32'(b) | ($urandom << 8));
    // read the registers back
    apb_read(gcb_pkg::REG_SCREEN_WIDTH, rd);
    if (rd !== {19'd0, 13'(w)})
      tracker.report_mismatch($sformatf("width reads %h, expected %h", rd, 13'(w)));
    apb_read(gcb_pkg::REG_SCREEN_HEIGHT, rd);
    if (rd !== {19'd0, 13'(h)})
      tracker.report_mismatch($sformatf("height reads %h, expected %h", rd, 13'(h)));
    apb_read(gcb_pkg::REG_BASELINE_BIAS, rd);
    if (rd !== {24'd0, 8'(b)})
      tracker.report_mismatch($sformatf("bias reads %h, expected %h", rd, 8'(b)));
    scr_w    = (w > glyph_blit_check_pkg::FB_MAX_WIDTH) ? glyph_blit_check_pkg::FB_MAX_WIDTH : w;
    scr_h    = (h > glyph_blit_check_pkg::FB_MAX_HEIGHT) ? glyph_blit_check_pkg::FB_MAX_HEIGHT : h;
    scr_bias = b;
  endtask

  // Mostly well-formed pen/header/bitmap runs, some noise and cut-short glyphs
  task automatic run_traffic(int budget);
    int stop_at;
    int r;
    int cols;
    int rows;
    int nbytes;
    int extra;
    int ax;
    int ay;
    int cov;
    stop_at = sent_count + budget;
    while (sent_count < stop_at) begin
      in_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        repeat ($urandom_range(1, 3))
          send_word(random_word(gcb_pkg::op_t'($urandom_range(0, 3))));
      end else if (r < 17) begin
        hold_until_drained();
      end else begin
        send_pen(near_edge(scr_w), near_edge(scr_h) - scr_bias, $urandom_range(0, 24'hFFFFFF));
        repeat ($urandom_range(1, 3)) begin
          r = $urandom_range(0, 99);
          if (r < 2) begin
            cols = 255;
            rows = 1;
          end else if (r < 4) begin
            cols = 1;
            rows = 255;
          end else if (r < 15) begin
            cols = $urandom_range(7, 20);
            rows = $urandom_range(1, 6);
          end else begin
            cols = $urandom_range(0, 6);
            rows = $urandom_range(0, 6);
          end
          ax = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 131071)) - 65536
                                            : int'($urandom_range(0, 1400));
          ay = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 131071)) - 65536 : 0;
          send_header(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 12)) - 2,
                      cols, rows, ax, ay);
          nbytes = cols * rows;
          if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, nbytes);
          extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
          repeat (nbytes + extra) begin
            r = $urandom_range(0, 9);
            cov = (r < 3) ? 0 : (r == 3) ? 255 : $urandom_range(1, 254);
            send_cov(cov);
          end
        end
      end
    end
  endtask

  // Randomly stall the write port, with calm stretches
  always @(negedge clk) begin
    out_ticks++;
    if (out_ticks % 300 == 0) out_calm = ($urandom_range(0, 2) == 0);
    if (out_hold > 0) begin
      out_ready = 1'b0;
      out_hold--;
    end else begin
      out_ready = 1'b1;
      if (!out_calm && $urandom_range(0, 4) == 0) out_hold = pick_gap();
    end
  end

  // Sample handshakes, feed the tracker, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_word(cur_word);
      if (out_valid && out_ready) tracker.check_write(out_write_address, out_pixel_color);
      if (psel && penable && pwrite && pready) tracker.write_reg(paddr[3:2], pwdata);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    cur_word = random_word(gcb_pkg::OP_NOP);
    tracker  = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Basic 2x2 glyph: full, zero, minimum and mid coverage
    send_pen(10, 20, 24'hFFFFFF);
    send_header(0, 0, 2, 2, 640, 0);
    send_cov(255);
    send_cov(0);
    send_cov(1);
    send_cov(128);
    // byte past the glyph end, then an ignored opcode
    send_cov(77);
    send_word(random_word(gcb_pkg::OP_NOP));
    // empty glyphs with extreme bearings and advances
    send_header(-1024, 1023, 0, 3, -65536, 65535);
    send_cov(9);
    send_header(1023, -1024, 3, 0, -65, -63);
    send_cov(5);
    // pen saturation at both ends
    send_pen(32767, -32768, 24'h000000);
    send_header(0, 0, 1, 1, 65535, 65535);
    send_cov(1);
    send_pen(-32768, 32767, 24'h123456);
    send_header(0, 0, 1, 1, -65536, -65536);
    // clipping at the left and bottom edges of the default screen
    send_pen(-1, 599, 24'hF81F07);
    send_header(0, 0, 3, 2, 64, -64);
    repeat (6) send_cov(200);
    // clipping at the right edge
    send_pen(1023, 0, 24'h07E0F8);
    send_header(0, 0, 2, 1, 0, 0);
    send_cov(255);
    send_cov(255);
    hold_until_drained();

    run_traffic(150);
    program_screen(1, 1, 0);
    run_traffic(110);
    program_screen(8191, 8191, 255);
    run_traffic(170);
    program_screen(0, 20, 16);
    run_traffic(60);
    program_screen(4096, 4096, 16);
    run_traffic(170);
    program_screen($urandom_range(1, 400), $urandom_range(1, 300), 16);
    run_traffic(150);
    program_screen($urandom_range(2, 4095), $urandom_range(2, 4095), $urandom_range(0, 255));
    run_traffic(100);

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (tracker.pending_writes.size() != 0)
      tracker.report_mismatch($sformatf("%0d writes never arrived",
                                        tracker.pending_writes.size()));
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
